@@ rtl/pre_pkg.sv @@
package pre_pkg;

    localparam int NUM_PAGES  = 64;
    localparam int MAX_FRAMES = 16;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int CNT_W      = FRAME_W + 1;

    // Configuration register indexes
    localparam logic CFG_POLICY     = 1'b0;
    localparam logic CFG_NUM_FRAMES = 1'b1;

    // Victim policy codes
    localparam logic [1:0] POL_FIFO   = 2'd0;
    localparam logic [1:0] POL_LRU    = 2'd1;
    localparam logic [1:0] POL_RANDOM = 2'd2;

    // Page table entry: frame when resident, swap slot otherwise
    typedef struct packed {
        logic [PAGE_W-1:0] loc;
        logic              resident;
        logic              touched;
    } pt_entry_t;

    // Frame table entry: occupant of a frame
    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] page;
    } ft_entry_t;

endpackage

@@ rtl/pre_ram.sv @@
module pre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/page_replacement_engine.sv @@
// Channel  | Ports                                    | Direction
// ---------+------------------------------------------+----------
// input    | s_valid s_ready s_page_number             | in
//          | s_random_frame                            |
// result   | m_valid m_ready m_hit m_frame m_evicted    | out
//          | m_victim_page m_victim_slot m_from_swap   |
//          | m_source_slot                             |
// config   | cfg_wr_en cfg_index cfg_wdata             | in
//
// One item at a time. A hit goes from the input transfer to m_valid through a lookup and
// a sequential pass over the recency memory, as long as the recency list.
// A miss adds a modulo reduction, on eviction a swap map scan plus a second recency
// pass, and a wrap of the fill pointer.
// After reset a clearing pass over all 64 entries zeroes the page table, swap map
// and frame table; no item is taken meanwhile.
// A result waits in the output register while the next item is processed; that item
// holds in its last state, with s_ready low, until the register is free.
module page_replacement_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [5:0]                  s_page_number,
    input  logic [3:0]                  s_random_frame,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_hit,
    output logic [3:0]                  m_frame,
    output logic                        m_evicted,
    output logic [5:0]                  m_victim_page,
    output logic [5:0]                  m_victim_slot,
    output logic                        m_from_swap,
    output logic [5:0]                  m_source_slot,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [4:0]                  cfg_wdata
);

    localparam int PW = pre_pkg::PAGE_W;
    localparam int FW = pre_pkg::FRAME_W;
    localparam int CW = pre_pkg::CNT_W;
    localparam int PT_W = $bits(pre_pkg::pt_entry_t);
    localparam int FT_W = $bits(pre_pkg::ft_entry_t);

    typedef enum logic [13:0] {
        ST_CLEAR  = 14'b00000000000001,
        ST_IDLE   = 14'b00000000000010,
        ST_LOOK   = 14'b00000000000100,
        ST_REDUCE = 14'b00000000001000,
        ST_OCC1   = 14'b00000000010000,
        ST_LRU1   = 14'b00000000100000,
        ST_LRU2   = 14'b00000001000000,
        ST_OCC2   = 14'b00000010000000,
        ST_SSCAN  = 14'b00000100000000,
        ST_EVWR   = 14'b00001000000000,
        ST_LOAD   = 14'b00010000000000,
        ST_RMV    = 14'b00100000000000,
        ST_APPEND = 14'b01000000000000,
        ST_DONE   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]    policy_reg;
    logic [4:0]    num_frames_reg;
    logic [CW-1:0] nf;

    logic [PW-1:0] page_reg, page_next;
    logic [3:0]    rnd_reg, rnd_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          fill_wrap;
    logic [CW-1:0] fp_reg, fp_next;
    logic [CW-1:0] rn_reg, rn_next;
    logic [FW-1:0] frame_reg, frame_next;
    logic          hit_reg, hit_next;
    logic          evicted_reg, evicted_next;
    logic [PW-1:0] vpage_reg, vpage_next;
    logic [PW-1:0] vslot_reg, vslot_next;
    logic          fromsw_reg, fromsw_next;
    logic [PW-1:0] sslot_reg, sslot_next;
    pre_pkg::pt_entry_t pe_reg, pe_next;
    logic [PW-1:0] clr_reg, clr_next;
    logic [PW:0]   scan_reg, scan_next;
    logic          scan_vld_reg, scan_vld_next;
    logic [PW-1:0] probe_reg, probe_next;
    logic [CW-1:0] rcount_reg, rcount_next;
    logic [CW-1:0] ri_reg, ri_next;
    logic [CW-1:0] rk_reg, rk_next;
    logic          rv_reg, rv_next;
    logic [PW-1:0] key_reg, key_next;
    logic          ret_load_reg, ret_load_next;
    logic          out_valid_reg, out_valid_next;

    // Memory ports
    logic               pt_we;
    logic [PW-1:0]      pt_waddr, pt_raddr;
    pre_pkg::pt_entry_t pt_wdata, pt_rdata;
    logic [PT_W-1:0]    pt_rbits;
    logic               sl_we;
    logic [PW-1:0]      sl_waddr;
    logic               sl_wdata, sl_rdata;
    logic               ft_we;
    logic [FW-1:0]      ft_waddr, ft_raddr;
    pre_pkg::ft_entry_t ft_wdata, ft_rdata;
    logic [FT_W-1:0]    ft_rbits;
    logic               rl_we;
    logic [FW-1:0]      rl_waddr, rl_raddr;
    logic [PW-1:0]      rl_wdata, rl_rdata;

    assign pt_rdata = pre_pkg::pt_entry_t'(pt_rbits);
    assign ft_rdata = pre_pkg::ft_entry_t'(ft_rbits);

    pre_ram #(.WIDTH(PT_W), .DEPTH(pre_pkg::NUM_PAGES)) u_page_table (
        .aclk(aclk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
        .raddr(pt_raddr), .rdata(pt_rbits)
    );

    pre_ram #(.WIDTH(1), .DEPTH(pre_pkg::NUM_PAGES)) u_swap_map (
        .aclk(aclk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
        .raddr(scan_reg[PW-1:0]), .rdata(sl_rdata)
    );

    pre_ram #(.WIDTH(FT_W), .DEPTH(pre_pkg::MAX_FRAMES)) u_frame_table (
        .aclk(aclk), .we(ft_we), .waddr(ft_waddr), .wdata(ft_wdata),
        .raddr(ft_raddr), .rdata(ft_rbits)
    );

    pre_ram #(.WIDTH(PW), .DEPTH(pre_pkg::MAX_FRAMES)) u_recency (
        .aclk(aclk), .we(rl_we), .waddr(rl_waddr), .wdata(rl_wdata),
        .raddr(rl_raddr), .rdata(rl_rdata)
    );

    // Saturate the frame count to 1..MAX_FRAMES
    always_comb begin
        if (num_frames_reg == 5'd0) begin
            nf = CW'(1);
        end else if (CW'(num_frames_reg) > CW'(pre_pkg::MAX_FRAMES)) begin
            nf = CW'(pre_pkg::MAX_FRAMES);
        end else begin
            nf = CW'(num_frames_reg);
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg     <= pre_pkg::POL_FIFO;
            num_frames_reg <= 5'd16;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pre_pkg::CFG_POLICY:     policy_reg     <= cfg_wdata[1:0];
                pre_pkg::CFG_NUM_FRAMES: num_frames_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Read address steering: each state sets up the data for the next one
    assign pt_raddr = (state_reg == ST_LRU1) ? rl_rdata : s_page_number;
    assign ft_raddr = (state_reg == ST_OCC1) ? rn_reg[FW-1:0] : fp_reg[FW-1:0];
    assign rl_raddr = (state_reg == ST_RMV) ? ri_reg[FW-1:0] : '0;

    assign s_ready = (state_reg == ST_IDLE);

    // A freshly loaded fill pointer still has to wrap below the frame count
    assign fill_wrap = !hit_reg && (fill_reg >= nf);

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        page_next      = page_reg;
        rnd_next       = rnd_reg;
        fill_next      = fill_reg;
        fp_next        = fp_reg;
        rn_next        = rn_reg;
        frame_next     = frame_reg;
        hit_next       = hit_reg;
        evicted_next   = evicted_reg;
        vpage_next     = vpage_reg;
        vslot_next     = vslot_reg;
        fromsw_next    = fromsw_reg;
        sslot_next     = sslot_reg;
        pe_next        = pe_reg;
        clr_next       = clr_reg;
        scan_next      = scan_reg;
        scan_vld_next  = scan_vld_reg;
        probe_next     = probe_reg;
        rcount_next    = rcount_reg;
        ri_next        = ri_reg;
        rk_next        = rk_reg;
        rv_next        = rv_reg;
        key_next       = key_reg;
        ret_load_next  = ret_load_reg;
        out_valid_next = out_valid_reg;

        pt_we    = 1'b0;
        pt_waddr = page_reg;
        pt_wdata = '0;
        sl_we    = 1'b0;
        sl_waddr = clr_reg;
        sl_wdata = 1'b0;
        ft_we    = 1'b0;
        ft_waddr = clr_reg[FW-1:0];
        ft_wdata = '0;
        rl_we    = 1'b0;
        rl_waddr = rk_reg[FW-1:0];
        rl_wdata = rl_rdata;

        // Drop the result once transferred
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                pt_we    = 1'b1;
                pt_waddr = clr_reg;
                sl_we    = 1'b1;
                ft_we    = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == PW'(pre_pkg::NUM_PAGES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    page_next    = s_page_number;
                    rnd_next     = s_random_frame;
                    hit_next     = 1'b0;
                    evicted_next = 1'b0;
                    vpage_next   = '0;
                    vslot_next   = '0;
                    fromsw_next  = 1'b0;
                    sslot_next   = '0;
                    state_next   = ST_LOOK;
                end
            end
            ST_LOOK: begin
                pe_next  = pt_rdata;
                ri_next  = '0;
                rk_next  = '0;
                rv_next  = 1'b0;
                key_next = page_reg;
                if (pt_rdata.resident) begin
                    hit_next      = 1'b1;
                    frame_next    = pt_rdata.loc[FW-1:0];
                    ret_load_next = 1'b0;
                    state_next    = ST_RMV;
                end else begin
                    fp_next    = CW'(fill_reg);
                    rn_next    = CW'(rnd_reg);
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                // Reduce fill pointer and random pick modulo the frame count
                if (fp_reg >= nf) begin
                    fp_next = fp_reg - nf;
                end
                if (rn_reg >= nf) begin
                    rn_next = rn_reg - nf;
                end
                if (fp_reg < nf && rn_reg < nf) begin
                    frame_next = fp_reg[FW-1:0];
                    state_next = ST_OCC1;
                end
            end
            ST_OCC1: begin
                vpage_next    = ft_rdata.page;
                scan_next     = '0;
                scan_vld_next = 1'b0;
                if (!ft_rdata.valid) begin
                    state_next = ST_LOAD;
                end else if (policy_reg == pre_pkg::POL_LRU && rcount_reg != '0) begin
                    state_next = ST_LRU1;
                end else if (policy_reg == pre_pkg::POL_RANDOM) begin
                    state_next = ST_OCC2;
                end else begin
                    state_next = ST_SSCAN;
                end
            end
            ST_LRU1: begin
                vpage_next = rl_rdata;
                state_next = ST_LRU2;
            end
            ST_LRU2: begin
                frame_next = pt_rdata.loc[FW-1:0];
                state_next = ST_SSCAN;
            end
            ST_OCC2: begin
                frame_next = rn_reg[FW-1:0];
                vpage_next = ft_rdata.page;
                state_next = ft_rdata.valid ? ST_SSCAN : ST_LOAD;
            end
            ST_SSCAN: begin
                // Find the lowest free swap slot, slot 0 when none is free, one probe per cycle
                if (scan_vld_reg && !sl_rdata) begin
                    vslot_next = probe_reg;
                    state_next = ST_EVWR;
                end else if (scan_reg[PW]) begin
                    vslot_next = '0;
                    state_next = ST_EVWR;
                end else begin
                    probe_next    = scan_reg[PW-1:0];
                    scan_vld_next = 1'b1;
                    scan_next     = scan_reg + 1'b1;
                end
            end
            ST_EVWR: begin
                evicted_next = 1'b1;
                sl_we        = 1'b1;
                sl_waddr     = vslot_reg;
                sl_wdata     = 1'b1;
                pt_we        = 1'b1;
                pt_waddr     = vpage_reg;
                pt_wdata     = '{loc: vslot_reg, resident: 1'b0, touched: 1'b1};
                ri_next       = '0;
                rk_next       = '0;
                rv_next       = 1'b0;
                key_next      = vpage_reg;
                ret_load_next = 1'b1;
                state_next    = ST_RMV;
            end
            ST_LOAD: begin
                if (pe_reg.touched) begin
                    fromsw_next = 1'b1;
                    sslot_next  = pe_reg.loc;
                    sl_we       = 1'b1;
                    sl_waddr    = pe_reg.loc;
                    sl_wdata    = 1'b0;
                end
                pt_we    = 1'b1;
                pt_waddr = page_reg;
                pt_wdata = '{loc: PW'(frame_reg), resident: 1'b1, touched: 1'b1};
                ft_we    = 1'b1;
                ft_waddr = frame_reg;
                ft_wdata = '{valid: 1'b1, page: page_reg};
                // Advance past the loaded frame; wrapped in the final state
                fill_next     = CW'(frame_reg) + CW'(1);
                ri_next       = '0;
                rk_next       = '0;
                rv_next       = 1'b0;
                key_next      = page_reg;
                ret_load_next = 1'b0;
                state_next    = ST_RMV;
            end
            ST_RMV: begin
                // Compact the recency list, dropping the key
                if (rv_reg && rl_rdata != key_reg) begin
                    rl_we   = 1'b1;
                    rk_next = rk_reg + 1'b1;
                end
                if (ri_reg < rcount_reg) begin
                    ri_next = ri_reg + 1'b1;
                    rv_next = 1'b1;
                end else begin
                    rv_next = 1'b0;
                    if (!rv_reg) begin
                        rcount_next = rk_reg;
                        state_next  = ret_load_reg ? ST_LOAD : ST_APPEND;
                    end
                end
            end
            ST_APPEND: begin
                rl_we       = 1'b1;
                rl_waddr    = rcount_reg[FW-1:0];
                rl_wdata    = page_reg;
                rcount_next = rcount_reg + 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (fill_wrap) begin
                    fill_next = fill_reg - nf;
                end else if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            fill_reg      <= '0;
            rcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            fill_reg      <= fill_next;
            rcount_reg    <= rcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        page_reg     <= page_next;
        rnd_reg      <= rnd_next;
        fp_reg       <= fp_next;
        rn_reg       <= rn_next;
        frame_reg    <= frame_next;
        hit_reg      <= hit_next;
        evicted_reg  <= evicted_next;
        vpage_reg    <= vpage_next;
        vslot_reg    <= vslot_next;
        fromsw_reg   <= fromsw_next;
        sslot_reg    <= sslot_next;
        pe_reg       <= pe_next;
        scan_reg     <= scan_next;
        scan_vld_reg <= scan_vld_next;
        probe_reg    <= probe_next;
        ri_reg       <= ri_next;
        rk_reg       <= rk_next;
        rv_reg       <= rv_next;
        key_reg      <= key_next;
        ret_load_reg <= ret_load_next;
    end

    // Output register, loaded on the finishing cycle only
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && !fill_wrap && (!out_valid_reg || m_ready)) begin
            m_hit         <= hit_reg;
            m_frame       <= frame_reg;
            m_evicted     <= evicted_reg;
            m_victim_page <= evicted_reg ? vpage_reg : '0;
            m_victim_slot <= vslot_reg;
            m_from_swap   <= fromsw_reg;
            m_source_slot <= sslot_reg;
        end
    end

    assign m_valid = out_valid_reg;

    // Recency list never holds more entries than MAX_FRAMES
    assert property (@(posedge aclk) disable iff (!aresetn)
        rcount_reg <= CW'(pre_pkg::MAX_FRAMES))
        else $error("recency count overflow");

    // The candidate frame is reduced below the frame count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OCC1) |-> (CW'(frame_reg) < nf))
        else $error("frame outside frame count");

    // One item at a time: no second transfer right after one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

    // The compaction write index never passes the read index
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RMV) |-> (rk_reg <= ri_reg))
        else $error("recency compaction overran");

endmodule

@@ tb/page_replacement_engine_test.sv @@
`timescale 1ns / 100ps

module page_replacement_engine_test;

    typedef struct packed {
        logic [5:0] page_number;
        logic [3:0] random_frame;
    } page_ref_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] frame;
        logic       evicted;
        logic [5:0] victim_page;
        logic [5:0] victim_slot;
        logic       from_swap;
        logic [5:0] source_slot;
    } ref_outcome_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [5:0] s_page_number;
    logic [3:0] s_random_frame;
    logic       m_valid;
    logic       m_ready;
    logic       m_hit;
    logic [3:0] m_frame;
    logic       m_evicted;
    logic [5:0] m_victim_page;
    logic [5:0] m_victim_slot;
    logic       m_from_swap;
    logic [5:0] m_source_slot;
    logic       cfg_wr_en;
    logic       cfg_index;
    logic [4:0] cfg_wdata;

    page_replacement_engine u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_page_number  (s_page_number),
        .s_random_frame (s_random_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_frame        (m_frame),
        .m_evicted      (m_evicted),
        .m_victim_page  (m_victim_page),
        .m_victim_slot  (m_victim_slot),
        .m_from_swap    (m_from_swap),
        .m_source_slot  (m_source_slot),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    // Predictor state
    logic [1:0] pr_policy;
    logic [4:0] pr_frames_reg;
    logic [5:0] pr_loc [pre_pkg::NUM_PAGES] = '{default: '0};
    logic       pr_resident [pre_pkg::NUM_PAGES] = '{default: 1'b0};
    logic       pr_touched [pre_pkg::NUM_PAGES] = '{default: 1'b0};
    logic       pr_slot_busy [pre_pkg::NUM_PAGES] = '{default: 1'b0};
    int         pr_fill = 0;
    int         pr_lru [$];

    page_ref_t    pending_refs [$];
    ref_outcome_t expected_outcomes [$];
    int           error_count = 0;
    int           send_idle_pct;
    int           recv_stall_pct;
    logic         hold_off_go = 1'b0;
    logic         hold_off;

    // Clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int find_occupant(int f);
        for (int p = 0; p < pre_pkg::NUM_PAGES; p++)
            if (pr_resident[p] && pr_loc[p] == f) return p;
        return pre_pkg::NUM_PAGES;
    endfunction

    function automatic void lru_drop(int page);
        for (int i = pr_lru.size() - 1; i >= 0; i--)
            if (pr_lru[i] == page) pr_lru.delete(i);
    endfunction

    function automatic ref_outcome_t predict_reference(page_ref_t r);
        ref_outcome_t o;
        int page, nf, fp, victim, fr, s;
        o = '0;
        page = r.page_number;
        nf = (pr_frames_reg == 0) ? 1
            : (pr_frames_reg > pre_pkg::MAX_FRAMES) ? pre_pkg::MAX_FRAMES
            : pr_frames_reg;
        if (pr_resident[page]) begin
            o.hit = 1'b1;
            o.frame = pr_loc[page][3:0];
        end else begin
            fp = pr_fill % nf;
            victim = find_occupant(fp);
            fr = fp;
            if (victim < pre_pkg::NUM_PAGES) begin
                if (pr_policy == pre_pkg::POL_LRU && pr_lru.size() > 0) begin
                    victim = pr_lru[0];
                    fr = pr_loc[victim];
                end else if (pr_policy == pre_pkg::POL_RANDOM) begin
                    fr = r.random_frame % nf;
                    victim = find_occupant(fr);
                end
            end
            if (victim < pre_pkg::NUM_PAGES) begin
                for (s = 0; s < pre_pkg::NUM_PAGES; s++)
                    if (!pr_slot_busy[s]) break;
                if (s >= pre_pkg::NUM_PAGES) s = 0;
                pr_slot_busy[s] = 1'b1;
                pr_resident[victim] = 1'b0;
                pr_loc[victim] = s[5:0];
                lru_drop(victim);
                o.evicted = 1'b1;
                o.victim_page = victim[5:0];
                o.victim_slot = s[5:0];
            end
            if (pr_touched[page]) begin
                o.from_swap = 1'b1;
                o.source_slot = pr_loc[page];
                pr_slot_busy[pr_loc[page]] = 1'b0;
            end
            pr_touched[page] = 1'b1;
            pr_resident[page] = 1'b1;
            pr_loc[page] = fr[5:0];
            o.frame = fr[3:0];
            pr_fill = (fr + 1) % nf;
        end
        lru_drop(page);
        if (pr_lru.size() >= pre_pkg::MAX_FRAMES) void'(pr_lru.pop_front());
        pr_lru.push_back(page);
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Driver: offer pending references, predict at each transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid        <= 1'b0;
            s_page_number  <= '0;
            s_random_frame <= '0;
        end else begin
            if (s_valid && s_ready) begin
                expected_outcomes.push_back(predict_reference(pending_refs.pop_front()));
            end
            if (!(s_valid && !s_ready)) begin
                if (pending_refs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid        <= 1'b1;
                    s_page_number  <= pending_refs[0].page_number;
                    s_random_frame <= pending_refs[0].random_frame;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    initial begin
        hold_off = 1'b0;
        wait (hold_off_go === 1'b1);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (2000) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        ref_outcome_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (m_hit !== want.hit) report_mismatch("hit", m_hit, want.hit);
                    if (m_frame !== want.frame) report_mismatch("frame", m_frame, want.frame);
                    if (m_evicted !== want.evicted)
                        report_mismatch("evicted", m_evicted, want.evicted);
                    if (m_victim_page !== want.victim_page)
                        report_mismatch("victim_page", m_victim_page, want.victim_page);
                    if (m_victim_slot !== want.victim_slot)
                        report_mismatch("victim_slot", m_victim_slot, want.victim_slot);
                    if (m_from_swap !== want.from_swap)
                        report_mismatch("from_swap", m_from_swap, want.from_swap);
                    if (m_source_slot !== want.source_slot)
                        report_mismatch("source_slot", m_source_slot, want.source_slot);
                end
            end
            if (hold_off) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic write_register(logic idx, logic [4:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == pre_pkg::CFG_POLICY) pr_policy = val[1:0];
        else pr_frames_reg = val;
    endtask

    task automatic drain_all();
        while (pending_refs.size() > 0 || s_valid || expected_outcomes.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic queue_ref(int page, int rnd);
        page_ref_t r;
        r.page_number = page[5:0];
        r.random_frame = rnd[3:0];
        pending_refs.push_back(r);
    endtask

    // Mostly a working set a bit larger than the frame count, some full range
    task automatic queue_random(int count, int span);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) < 8) queue_ref($urandom_range(span - 1), $urandom);
            else queue_ref($urandom, $urandom);
        end
    endtask

    initial begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cfg_wr_en = 1'b0;
        cfg_index = pre_pkg::CFG_POLICY;
        cfg_wdata = '0;
        pr_policy = pre_pkg::POL_FIFO;
        pr_frames_reg = 5'd16;
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (70) @(posedge aclk);

        // Directed: tiny frame count, FIFO, extremes, reloads from swap
        write_register(pre_pkg::CFG_NUM_FRAMES, 5'd1);
        queue_ref(0, 0);
        queue_ref(63, 15);
        queue_ref(63, 0);
        queue_ref(0, 15);
        queue_ref(63, 5);
        drain_all();
        // Raising the count leaves the fill pointer; random policy hits empty frames
        write_register(pre_pkg::CFG_POLICY, 5'(pre_pkg::POL_RANDOM));
        write_register(pre_pkg::CFG_NUM_FRAMES, 5'd3);
        queue_ref(5, 15);
        queue_ref(6, 2);
        queue_ref(7, 1);
        queue_ref(8, 15);
        queue_ref(0, 0);
        drain_all();
        write_register(pre_pkg::CFG_POLICY, 5'(pre_pkg::POL_LRU));
        queue_ref(9, 0);
        queue_ref(8, 0);
        queue_ref(10, 0);
        queue_ref(9, 0);
        drain_all();
        // Out of range frame count and policy code three
        write_register(pre_pkg::CFG_NUM_FRAMES, 5'd0);
        write_register(pre_pkg::CFG_POLICY, 5'd3);
        queue_ref(11, 7);
        queue_ref(12, 7);
        drain_all();
        write_register(pre_pkg::CFG_NUM_FRAMES, 5'd31);
        queue_ref(13, 15);
        queue_ref(14, 3);
        drain_all();

        // Random phases across policies, frame counts and idling
        for (int ph = 0; ph < 12; ph++) begin
            int nf;
            nf = (ph % 4 == 0) ? 16 : (ph % 4 == 1) ? 1 : $urandom_range(2, 15);
            write_register(pre_pkg::CFG_POLICY, 5'(ph % 3));
            write_register(pre_pkg::CFG_NUM_FRAMES, nf[4:0]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            queue_random(52, nf + 4);
            if (ph == 5) hold_off_go = 1'b1;
            drain_all();
        end

        if (error_count == 0) begin
            $display("page_replacement_engine_test: PASS");
        end else begin
            $display("page_replacement_engine_test: FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("page_replacement_engine_test: FAIL");
        $finish;
    end

endmodule
